// ===== src/oaec_pkg.sv =====
// Shared types, constants and helpers for the overlap alignment edit counter.
// Used by oaec_cell and overlap_alignment_edit_counter; depends on nothing.
`default_nettype none

package oaec_pkg;

   // Capacity of each read, in bases.
   localparam int MAX_LEN = 128;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int IDX_W   = $clog2(MAX_LEN);
   localparam int T_W     = LEN_W + 1;
   // Scores stay within two read lengths times the largest match reward.
   localparam int SCORE_W = 16 + LEN_W + 2;

   // Request commands.
   localparam logic [1:0] CMD_FIRST  = 2'd0;
   localparam logic [1:0] CMD_SECOND = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_MATCH    = 2'd0;
   localparam logic [1:0] REG_MISMATCH = 2'd1;
   localparam logic [1:0] REG_GAP      = 2'd2;
   localparam logic [1:0] REG_SKEW     = 2'd3;

   // Character codes.
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;

   // Move codes kept for each matrix cell.
   typedef enum logic [1:0] {
      MV_M = 2'd0,
      MV_D = 2'd1,
      MV_J = 2'd2,
      MV_I = 2'd3
   } move_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] base;
   } req_type;

   typedef struct packed {
      logic [8:0] edit_count;
      logic       overflow;
   } rsp_type;

   // One row of the first read as it moves down the cell chain.
   typedef struct packed {
      logic             valid;
      logic             last_row;
      logic [7:0]       base;
      logic [IDX_W-1:0] row;
   } row_type;

   // Weights and the second read's length shared by every cell during a run.
   typedef struct packed {
      logic [7:0]       match;
      logic [7:0]       mismatch;
      logic [7:0]       gap;
      logic [15:0]      skew_match;
      logic [LEN_W-1:0] len2;
   } cell_cfg_type;

   // Fold a-z to upper case.
   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/oaec_cell.sv =====
// One column cell of the alignment array: holds one base of the second read,
// its running score and the move codes of its column. Depends on oaec_pkg.
`default_nettype none

module oaec_cell
   import oaec_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        clear,
   input  wire logic [IDX_W-1:0]            col_idx,
   input  wire logic                        load_en,
   input  wire logic [IDX_W-1:0]            load_idx,
   input  wire logic [7:0]                  load_base,
   input  wire cell_cfg_type                cfg,
   input  wire row_type                     row_in,
   input  wire logic signed [SCORE_W-1:0]   h_left,
   input  wire logic signed [SCORE_W-1:0]   h_diag,
   input  wire logic [IDX_W-1:0]            rd_addr,
   output row_type                          row_out,
   output logic signed [SCORE_W-1:0]        h_out,
   output logic signed [SCORE_W-1:0]        h_prev_out,
   output move_type                         rd_code,
   output logic                             base_is_c
);

   logic [7:0]                b_ff;
   row_type                   row_ff;
   logic signed [SCORE_W-1:0] h_ff;
   logic signed [SCORE_W-1:0] h_prev_ff;
   move_type                  rd_code_ff;
   move_type                  trace_mem [MAX_LEN];

   logic                      active;
   logic                      last_col;
   logic                      b_is_a;
   logic                      same;
   logic signed [SCORE_W-1:0] mm;
   logic signed [SCORE_W-1:0] gi;
   logic signed [SCORE_W-1:0] gj;
   logic signed [SCORE_W-1:0] sd;
   logic signed [SCORE_W-1:0] su;
   logic signed [SCORE_W-1:0] sl;
   logic signed [SCORE_W-1:0] best;
   move_type                  code;

   // Cell evaluation for the row currently passing this column.
   always_comb begin
      active   = row_in.valid && ({1'b0, col_idx} < cfg.len2);
      last_col = (({1'b0, col_idx} + LEN_W'(1)) == cfg.len2);
      b_is_a   = (fold_upper(b_ff) == CHAR_A);
      same     = (fold_upper(row_in.base) == fold_upper(b_ff));
      if (same) begin
         mm = b_is_a ? $signed({{(SCORE_W-8){1'b0}}, cfg.match})
                     : $signed({{(SCORE_W-16){1'b0}}, cfg.skew_match});
      end else begin
         mm = -$signed({{(SCORE_W-8){1'b0}}, cfg.mismatch});
      end
      gi = row_in.last_row ? '0 : $signed({{(SCORE_W-8){1'b0}}, cfg.gap});
      gj = last_col ? '0 : $signed({{(SCORE_W-8){1'b0}}, cfg.gap});
      sd = h_diag + mm;
      su = h_ff - gj;
      sl = h_left - gi;
      if (sd >= su && sd >= sl) begin
         best = sd;
         code = (row_in.base == (b_is_a ? CHAR_A : CHAR_C)) ? MV_M : MV_D;
      end else if (su >= sl) begin
         best = su;
         code = MV_J;
      end else begin
         best = sl;
         code = MV_I;
      end
   end

   // Pass the row on and keep the latest two scores of this column.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff.valid <= 1'b0;
      end else begin
         row_ff.valid <= row_in.valid;
      end
      row_ff.last_row <= row_in.last_row;
      row_ff.base     <= row_in.base;
      row_ff.row      <= row_in.row;
      if (clear) begin
         h_ff      <= '0;
         h_prev_ff <= '0;
      end else if (active) begin
         h_prev_ff <= h_ff;
         h_ff      <= best;
      end
      if (load_en && load_idx == col_idx) begin
         b_ff <= load_base;
      end
   end

   // Move codes of this column, one entry per row.
   always_ff @(posedge clock) begin
      if (active) begin
         trace_mem[row_in.row] <= code;
      end
      rd_code_ff <= trace_mem[rd_addr];
   end

   assign row_out    = row_ff;
   assign h_out      = h_ff;
   assign h_prev_out = h_prev_ff;
   assign rd_code    = rd_code_ff;
   assign base_is_c  = (b_ff == CHAR_C);

endmodule

`default_nettype wire

// ===== src/overlap_alignment_edit_counter.sv =====
// Top level of the overlap alignment edit counter: load, fill and traceback.
// Depends on oaec_pkg and oaec_cell.
`default_nettype none

// Bases are loaded one request per cycle while the block is idle. A run
// request fills the score matrix on a chain of MAX_LEN column cells as a
// diagonal wavefront, then traces back one step at a time (a registered read
// of the move-code memories, then an update), and then offers its result.
// No request is taken from the run request until the result is registered.
module overlap_alignment_edit_counter
   import oaec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_TB_ADDR,
      S_TB_EVAL,
      S_DONE
   } state_type;

   state_type        state_ff;
   logic [7:0]       match_ff;
   logic [7:0]       mismatch_ff;
   logic [7:0]       gap_ff;
   logic [7:0]       skew_ff;
   logic [15:0]      skew_match_ff;
   logic [LEN_W-1:0] len1_ff;
   logic [LEN_W-1:0] len2_ff;
   logic             ovf_ff;
   logic [T_W-1:0]   t_ff;
   logic             feed_valid_ff;
   logic             feed_last_ff;
   logic [IDX_W-1:0] feed_row_ff;
   logic [LEN_W-1:0] i_ff;
   logic [LEN_W-1:0] j_ff;
   logic [8:0]       edits_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic [7:0]       r1_mem [MAX_LEN];
   logic [7:0]       r1_rd_ff;

   logic             req_take;
   logic             start;
   logic [IDX_W-1:0] r1_addr;
   logic [IDX_W-1:0] tb_row;
   logic [IDX_W-1:0] tb_col;
   cell_cfg_type     cfg;
   row_type          chain_row [MAX_LEN+1];
   logic signed [SCORE_W-1:0] chain_h [MAX_LEN+1];
   logic signed [SCORE_W-1:0] chain_hp [MAX_LEN+1];
   move_type         cell_code [MAX_LEN];
   logic [MAX_LEN-1:0] cell_is_c;
   move_type         tb_code;
   logic             tb_r2_c;
   logic             tb_r1_c;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign start     = req_take && (req_data.cmd == CMD_RUN);

   // Shared weights and second read length for the cells.
   assign cfg.match      = match_ff;
   assign cfg.mismatch   = mismatch_ff;
   assign cfg.gap        = gap_ff;
   assign cfg.skew_match = skew_match_ff;
   assign cfg.len2       = len2_ff;

   // Traceback reads matrix row i from address i-1 and column j from cell j-1.
   assign tb_row  = IDX_W'(i_ff - LEN_W'(1));
   assign tb_col  = IDX_W'(j_ff - LEN_W'(1));
   assign r1_addr = (state_ff == S_FILL) ? IDX_W'(t_ff) : tb_row;
   assign tb_code = cell_code[tb_col];
   assign tb_r2_c = cell_is_c[tb_col];
   assign tb_r1_c = (r1_rd_ff == CHAR_C);

   // Head of the chain: the first read, one row per cycle.
   assign chain_row[0].valid    = feed_valid_ff;
   assign chain_row[0].last_row = feed_last_ff;
   assign chain_row[0].base     = r1_rd_ff;
   assign chain_row[0].row      = feed_row_ff;
   assign chain_h[0]            = '0;
   assign chain_hp[0]           = '0;

   // Chain of column cells.
   for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
      oaec_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (start),
         .col_idx    (IDX_W'(g)),
         .load_en    (req_take && req_data.cmd == CMD_SECOND && len2_ff < LEN_W'(MAX_LEN)),
         .load_idx   (IDX_W'(len2_ff)),
         .load_base  (req_data.base),
         .cfg        (cfg),
         .row_in     (chain_row[g]),
         .h_left     (chain_h[g]),
         .h_diag     (chain_hp[g]),
         .rd_addr    (tb_row),
         .row_out    (chain_row[g+1]),
         .h_out      (chain_h[g+1]),
         .h_prev_out (chain_hp[g+1]),
         .rd_code    (cell_code[g]),
         .base_is_c  (cell_is_c[g])
      );
   end

   // First read store.
   always_ff @(posedge clock) begin
      if (req_take && req_data.cmd == CMD_FIRST && len1_ff < LEN_W'(MAX_LEN)) begin
         r1_mem[IDX_W'(len1_ff)] <= req_data.base;
      end
      r1_rd_ff <= r1_mem[r1_addr];
   end

   // Configuration registers and the skewed reward product.
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= 8'd1;
         mismatch_ff <= 8'd1;
         gap_ff      <= 8'd1;
         skew_ff     <= 8'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MATCH:    match_ff    <= csr_wdata;
            REG_MISMATCH: mismatch_ff <= csr_wdata;
            REG_GAP:      gap_ff      <= csr_wdata;
            REG_SKEW:     skew_ff     <= csr_wdata;
            default:      ;
         endcase
      end
      skew_match_ff <= skew_ff * match_ff;
   end

   // Sequencer: loading, fill, traceback and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len1_ff       <= '0;
         len2_ff       <= '0;
         ovf_ff        <= 1'b0;
         feed_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         t_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         edits_ff      <= '0;
      end else begin
         // The final state loads the result register itself.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         feed_valid_ff <= (state_ff == S_FILL) && ({1'b0, t_ff} < {2'b0, len1_ff});
         feed_last_ff  <= ({1'b0, t_ff} + (T_W+1)'(1)) == {2'b0, len1_ff};
         feed_row_ff   <= IDX_W'(t_ff);
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  unique case (req_data.cmd)
                     CMD_FIRST: begin
                        if (len1_ff < LEN_W'(MAX_LEN)) len1_ff <= len1_ff + LEN_W'(1);
                        else ovf_ff <= 1'b1;
                     end
                     CMD_SECOND: begin
                        if (len2_ff < LEN_W'(MAX_LEN)) len2_ff <= len2_ff + LEN_W'(1);
                        else ovf_ff <= 1'b1;
                     end
                     CMD_RUN: begin
                        state_ff <= S_FILL;
                        t_ff     <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_FILL: begin
               if ({1'b0, t_ff} == {2'b0, len1_ff} + {2'b0, len2_ff} + (T_W+1)'(1)) begin
                  state_ff <= S_TB_ADDR;
                  i_ff     <= len1_ff;
                  j_ff     <= len2_ff;
                  edits_ff <= '0;
               end else begin
                  t_ff <= t_ff + T_W'(1);
               end
            end
            S_TB_ADDR: begin
               if (j_ff == '0) begin
                  state_ff <= S_DONE;
               end else if (i_ff == '0) begin
                  j_ff <= j_ff - LEN_W'(1);
               end else begin
                  state_ff <= S_TB_EVAL;
               end
            end
            S_TB_EVAL: begin
               state_ff <= S_TB_ADDR;
               unique case (tb_code)
                  MV_M: begin
                     i_ff <= i_ff - LEN_W'(1);
                     j_ff <= j_ff - LEN_W'(1);
                  end
                  MV_D: begin
                     edits_ff <= edits_ff + 9'd1;
                     i_ff     <= i_ff - LEN_W'(1);
                     j_ff     <= j_ff - LEN_W'(1);
                  end
                  MV_J: begin
                     if (j_ff < len2_ff && tb_r1_c) edits_ff <= edits_ff + 9'd1;
                     i_ff <= i_ff - LEN_W'(1);
                  end
                  MV_I: begin
                     if (i_ff < len1_ff && tb_r2_c) edits_ff <= edits_ff + 9'd1;
                     j_ff <= j_ff - LEN_W'(1);
                  end
                  default: ;
               endcase
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.edit_count <= edits_ff;
                  rsp_data_ff.overflow   <= ovf_ff;
                  len1_ff                <= '0;
                  len2_ff                <= '0;
                  ovf_ff                 <= 1'b0;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // Traceback position never leaves the filled matrix.
   a_tb_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TB_ADDR || state_ff == S_TB_EVAL) |-> (i_ff <= len1_ff && j_ff <= len2_ff))
      else $error("traceback outside the matrix");

   // A new result only comes from the final state of a run.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside a run");

   // Read lengths never exceed the store size.
   a_len: assert property (@(posedge clock) disable iff (reset)
      (len1_ff <= LEN_W'(MAX_LEN)) && (len2_ff <= LEN_W'(MAX_LEN)))
      else $error("read length beyond capacity");

   // Lengths hold still while the matrix is being filled or traced.
   a_len_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL || state_ff == S_TB_ADDR || state_ff == S_TB_EVAL)
      |=> ($stable(len1_ff) && $stable(len2_ff)))
      else $error("lengths changed during a run");
`endif

endmodule

`default_nettype wire

// ===== tb/overlap_alignment_edit_counter_tb.sv =====
// Self-checking testbench for overlap_alignment_edit_counter: loads reads, runs
// alignments and compares each edit count and overflow flag with a predictor.
// Depends on oaec_pkg and the RTL under src only.
`default_nettype none

module overlap_alignment_edit_counter_tb;
   import oaec_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Command code that the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   overlap_alignment_edit_counter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state: weights and the two reads.
   int unsigned match_w, mismatch_w, gap_w, skew_w;
   logic [7:0]  read1 [MAX_LEN];
   logic [7:0]  read2 [MAX_LEN];
   int unsigned len1, len2;
   bit          dropped;
   rsp_type     expected_counts[$];

   bit failed;
   bit rx_hold;          // long receiver hold-off request
   bit calm;             // no random idling while set
   longint unsigned cycle_count;

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Fold lower case to upper case.
   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
   endfunction

   // Fill the overlap matrix and trace back, counting edits; a gap counts only against a C.
   function automatic logic [8:0] count_edits();
      int      row [MAX_LEN+1];
      move_type mv [MAX_LEN+1][MAX_LEN+1];
      int      i, j, gi, gj, diag, mm, sd, su, sl, edits;
      bit      b_is_a;
      for (j = 0; j <= len2; j++) begin
         row[j] = 0;
         mv[0][j] = MV_I;
      end
      for (i = 1; i <= len1; i++) mv[i][0] = MV_J;
      for (i = 0; i < len1; i++) begin
         gi = (i + 1 == len1) ? 0 : gap_w;
         diag = row[0];
         row[0] = 0;
         for (j = 0; j < len2; j++) begin
            gj = (j + 1 == len2) ? 0 : gap_w;
            b_is_a = to_upper(read2[j]) == CHAR_A;
            if (to_upper(read1[i]) == to_upper(read2[j])) begin
               mm = b_is_a ? match_w : skew_w * match_w;
            end else begin
               mm = -mismatch_w;
            end
            sd = diag + mm;
            su = row[j+1] - gj;
            sl = row[j] - gi;
            diag = row[j+1];
            if (sd >= su && sd >= sl) begin
               row[j+1] = sd;
               mv[i+1][j+1] = (read1[i] == (b_is_a ? CHAR_A : CHAR_C)) ? MV_M : MV_D;
            end else if (su >= sl) begin
               row[j+1] = su;
               mv[i+1][j+1] = MV_J;
            end else begin
               row[j+1] = sl;
               mv[i+1][j+1] = MV_I;
            end
         end
      end
      i = len1;
      j = len2;
      edits = 0;
      while (j > 0) begin
         if (mv[i][j] == MV_M || mv[i][j] == MV_D) begin
            if (mv[i][j] == MV_D) edits++;
            if (i > 0) i--;
            j--;
         end else if (mv[i][j] == MV_J && i > 0) begin
            if (j < len2 && read1[i-1] == CHAR_C) edits++;
            i--;
         end else begin
            if (i > 0 && i < len1 && read2[j-1] == CHAR_C) edits++;
            j--;
         end
      end
      return edits > 511 ? 9'd511 : edits[8:0];
   endfunction

   // Apply one accepted request to the predictor.
   function automatic void predict(input req_type r);
      rsp_type e;
      case (r.cmd)
         CMD_FIRST: begin
            if (len1 < MAX_LEN) read1[len1++] = r.base;
            else dropped = 1'b1;
         end
         CMD_SECOND: begin
            if (len2 < MAX_LEN) read2[len2++] = r.base;
            else dropped = 1'b1;
         end
         CMD_RUN: begin
            e.edit_count = count_edits();
            e.overflow = dropped;
            expected_counts.push_back(e);
            len1 = 0;
            len2 = 0;
            dropped = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   // Send one request, idling at random beforehand. Valid stays high after
   // the handshake so that a following request can go out back to back.
   task automatic send(input logic [1:0] cmd, input logic [7:0] base);
      req_type r;
      if (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      r.cmd = cmd;
      r.base = base;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict(r);
   endtask

   // Wait until all results are in, plus the block's trailing latency.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_MATCH:    match_w = val;
         REG_MISMATCH: mismatch_w = val;
         REG_GAP:      gap_w = val;
         default:      skew_w = val;
      endcase
   endtask

   task automatic set_weights(input logic [7:0] m, input logic [7:0] mm,
                              input logic [7:0] g, input logic [7:0] s);
      drain();
      write_reg(REG_MATCH, m);
      write_reg(REG_MISMATCH, mm);
      write_reg(REG_GAP, g);
      write_reg(REG_SKEW, s);
      csr_wr_en <= 1'b0;
   endtask

   // Pick a base biased toward nucleotide letters in both cases.
   function automatic logic [7:0] pick_base();
      int unsigned k;
      logic [7:0] letters [8] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74};
      k = $urandom_range(9);
      return (k < 8) ? letters[k] : 8'($urandom);
   endfunction

   // Load two random reads and run an alignment.
   task automatic random_pair(input int max1, input int max2);
      int n1, n2, k;
      n1 = $urandom_range(max1);
      n2 = $urandom_range(max2);
      for (k = 0; k < n1 + n2; k++) begin
         if ($urandom_range(1)) send(CMD_FIRST, pick_base());
         else send(CMD_SECOND, pick_base());
      end
      if ($urandom_range(19) == 0) send(CMD_UNUSED, 8'($urandom));
      send(CMD_RUN, 8'($urandom));
   endtask

   // Directed: empty reads, case handling, byte extremes, unused command.
   task automatic test_directed();
      send(CMD_RUN, 8'h00);
      send(CMD_FIRST, CHAR_C);
      send(CMD_RUN, 8'hff);
      send(CMD_SECOND, 8'h63);
      send(CMD_RUN, 8'h00);
      send(CMD_FIRST, CHAR_C);
      send(CMD_FIRST, 8'h61);
      send(CMD_FIRST, 8'h00);
      send(CMD_FIRST, 8'hff);
      send(CMD_SECOND, CHAR_A);
      send(CMD_SECOND, 8'h63);
      send(CMD_SECOND, CHAR_C);
      send(CMD_SECOND, 8'h00);
      send(CMD_UNUSED, 8'haa);
      send(CMD_SECOND, 8'hff);
      send(CMD_RUN, 8'h55);
      send(CMD_FIRST, 8'h7a);
      send(CMD_SECOND, 8'h5a);
      send(CMD_RUN, 8'h00);
   endtask

   // Weight settings including extremes and a zero skew.
   task automatic test_weights();
      int k;
      set_weights(8'd255, 8'd255, 8'd255, 8'd255);
      for (k = 0; k < 3; k++) random_pair(10, 10);
      set_weights(8'd0, 8'd0, 8'd0, 8'd0);
      for (k = 0; k < 3; k++) random_pair(10, 10);
      set_weights(8'd3, 8'd1, 8'd2, 8'd1);
      for (k = 0; k < 3; k++) random_pair(10, 10);
   endtask

   // Overflow on both reads: one full-size run each.
   task automatic test_overflow();
      int k;
      set_weights(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      for (k = 0; k < MAX_LEN + 2; k++) send(CMD_FIRST, pick_base());
      for (k = 0; k < MAX_LEN; k++) send(CMD_SECOND, pick_base());
      send(CMD_RUN, 8'h00);
      for (k = 0; k < 3; k++) send(CMD_FIRST, pick_base());
      for (k = 0; k < MAX_LEN + 1; k++) send(CMD_SECOND, pick_base());
      send(CMD_RUN, 8'h00);
   endtask

   // Receiver holds off while short runs keep arriving; then sender waits.
   task automatic test_pressure();
      int k;
      rx_hold = 1'b1;
      for (k = 0; k < 6; k++) random_pair(3, 3);
      drain();
      calm = 1'b1;
      for (k = 0; k < 10; k++) random_pair(6, 6);
      calm = 1'b0;
   endtask

   // Random runs with random weights between phases.
   task automatic test_random();
      int p, k;
      for (p = 0; p < 6; p++) begin
         set_weights(8'($urandom_range(8)), 8'($urandom_range(8)),
                     8'($urandom_range(8)), 8'($urandom_range(255)));
         for (k = 0; k < 3; k++) random_pair(9, 9);
      end
   endtask

   // Receiver stall: random, with a long quiet stretch and a counted hold-off.
   initial begin
      int hold_cycles;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold) begin
            rsp_stall <= 1'b1;
            for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge clock);
            rx_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 10);
         end
      end
   end

   // Result checker against the oldest expected count.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $error("unexpected result %0d", rsp_data.edit_count);
            failed = 1'b1;
         end else begin
            e = expected_counts.pop_front();
            if (rsp_data.edit_count !== e.edit_count) begin
               $error("edit_count expected %0d actual %0d", e.edit_count,
                      rsp_data.edit_count);
               failed = 1'b1;
            end
            if (rsp_data.overflow !== e.overflow) begin
               $error("overflow expected %0d actual %0d", e.overflow, rsp_data.overflow);
               failed = 1'b1;
            end
         end
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 64'd2000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      cycle_count = 0;
      failed = 1'b0;
      rx_hold = 1'b0;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = REG_MATCH;
      csr_wdata = 8'd0;
      match_w = 1;
      mismatch_w = 1;
      gap_w = 1;
      skew_w = 1;
      len1 = 0;
      len2 = 0;
      dropped = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_weights();
      test_overflow();
      test_pressure();
      test_random();
      drain();
      repeat (600) @(posedge clock);
      if (!failed && expected_counts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
